FILE: rtl/core/hcfs_pkg.sv
`default_nettype none

package hcfs_pkg;

    // Frame length in bytes, and the widths that follow from it.
    localparam int FRAME_LEN = 44;
    localparam int IdxW      = $clog2(FRAME_LEN);
    localparam int CntW      = $clog2(FRAME_LEN + 1);
    localparam int WrapW     = ((IdxW > CntW) ? IdxW : CntW) + 1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic append;   // write the input byte at the tail
        logic rd;       // read the head byte into the read register
        logic drop;     // remove the head byte from the window
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic empty;      // window holds no byte
        logic full;       // window holds a whole frame
        logic hdr_match;  // read register equals the header byte
        logic sum_zero;   // wrapping sum of the window is zero
        logic last;       // exactly one byte left in the window
    } t_sts;

endpackage

`default_nettype wire

FILE: rtl/core/header_checksum_frame_sync_unit.sv
// Header and checksum frame synchronizer for a serial byte stream.
// Input channel (i_in_valid / o_in_ready / i_in_byte) takes one received word
// per handshake. Bytes ahead of the header byte are discarded; from a header
// byte on, FRAME_LEN bytes are collected in a ring-buffer window. When the
// window is full and its 8-bit wrapping sum is zero, the frame is sent on the
// output channel (o_out_valid / i_out_ready / o_frame_byte / o_frame_last),
// one word per handshake, with o_frame_last set on the final byte. A bad
// checksum drops the first byte and rescans the rest for the next header.
// The header byte is written through i_cfg_valid / o_cfg_ready, which is
// always ready; write it only while the block is idle.
// Sequence: an input word that leaves the window starting with a header byte
// gets a window read and a compare before the next word is taken; each byte
// discarded while rescanning adds one more read and compare. A completed frame
// shows its first byte after the read and compare of the last input word, and
// each further byte after a new read once the previous one is taken, as every
// byte comes through the window memory's single registered read port.
// Input and output are served one at a time: while a frame is being sent,
// no input is taken, and a stalled receiver simply holds the block in place.
// Reset (i_rst_n low, synchronous) empties the window and sets the header
// byte to zero; the window memory itself is not cleared.
`default_nettype none

module header_checksum_frame_sync_unit
    import hcfs_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [7:0] i_in_byte,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic      [7:0] o_frame_byte,
    output logic            o_frame_last,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [7:0] i_cfg_header_byte
);

    t_cmd cmd;
    t_sts sts;

    // The configuration register never pushes back.
    assign o_cfg_ready = 1'b1;

    hcfs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid)
    );

    hcfs_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_in_byte         (i_in_byte),
        .i_cfg_wr          (i_cfg_valid),
        .i_cfg_header_byte (i_cfg_header_byte),
        .o_sts             (sts),
        .o_rdata           (o_frame_byte)
    );

    // While a frame is sent, the byte on the output is the window's head,
    // so it is the last one exactly when one byte remains.
    assign o_frame_last = sts.last;

endmodule

`default_nettype wire

FILE: rtl/core/hcfs_dp.sv
`default_nettype none

module hcfs_dp
    import hcfs_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_cmd       i_cmd,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_cfg_wr,
    input  wire logic [7:0] i_cfg_header_byte,
    output t_sts            o_sts,
    output logic      [7:0] o_rdata
);

    logic [7:0]      r_mem [FRAME_LEN];
    logic [7:0]      r_rdata;
    logic [7:0]      r_header, n_header;
    logic [IdxW-1:0] r_head, n_head;
    logic [CntW-1:0] r_count, n_count;
    logic [7:0]      r_sum, n_sum;

    logic [WrapW-1:0] tail_ext;
    logic [IdxW-1:0]  tail;

    // The window is a ring buffer: the tail is head plus count, wrapped once.
    always_comb begin
        tail_ext = WrapW'(r_head) + WrapW'(r_count);
        if (tail_ext >= WrapW'(FRAME_LEN)) begin
            tail_ext = tail_ext - WrapW'(FRAME_LEN);
        end
        tail = tail_ext[IdxW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.append) begin
            r_mem[tail] <= i_in_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rdata <= r_mem[r_head];
        end
    end

    always_comb begin
        n_header = r_header;
        n_head   = r_head;
        n_count  = r_count;
        n_sum    = r_sum;
        if (i_cfg_wr) begin
            n_header = i_cfg_header_byte;
        end
        if (i_cmd.append) begin
            n_count = r_count + CntW'(1);
            n_sum   = r_sum + i_in_byte;
        end else if (i_cmd.drop) begin
            n_count = r_count - CntW'(1);
            n_sum   = r_sum - r_rdata;
            n_head  = (r_head == IdxW'(FRAME_LEN - 1)) ? '0 : r_head + IdxW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header <= '0;
            r_head   <= '0;
            r_count  <= '0;
            r_sum    <= '0;
        end else begin
            r_header <= n_header;
            r_head   <= n_head;
            r_count  <= n_count;
            r_sum    <= n_sum;
        end
    end

    assign o_rdata         = r_rdata;
    assign o_sts.empty     = (r_count == '0);
    assign o_sts.full      = (r_count == CntW'(FRAME_LEN));
    assign o_sts.hdr_match = (r_rdata == r_header);
    assign o_sts.sum_zero  = (r_sum == '0);
    assign o_sts.last      = (r_count == CntW'(1));

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntW'(FRAME_LEN))
        else $error("window count exceeds the frame length");

    a_head_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head < IdxW'(FRAME_LEN))
        else $error("head pointer out of range");

    a_no_append_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.append |-> !o_sts.full)
        else $error("byte appended to a full window");

    a_drop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.drop |-> !o_sts.empty && !i_cmd.append)
        else $error("drop from an empty window or together with an append");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/hcfs_ctrl.sv
`default_nettype none

module hcfs_ctrl
    import hcfs_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    input  wire logic i_out_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd,
    output logic      o_in_ready,
    output logic      o_out_valid
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_CHK,
        S_EOUT,
        S_ERD
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.append = 1'b1;
                    n_state      = S_RD;
                end
            end
            S_RD: begin
                if (i_sts.empty) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.rd = 1'b1;
                    n_state  = S_CHK;
                end
            end
            S_CHK: begin
                if (!i_sts.hdr_match) begin
                    o_cmd.drop = 1'b1;
                    n_state    = S_RD;
                end else if (i_sts.full) begin
                    if (i_sts.sum_zero) begin
                        n_state = S_EOUT;
                    end else begin
                        o_cmd.drop = 1'b1;
                        n_state    = S_RD;
                    end
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_EOUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    o_cmd.drop = 1'b1;
                    n_state    = i_sts.last ? S_IDLE : S_ERD;
                end
            end
            S_ERD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_EOUT;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef NO_ASSERTIONS
    a_emit_only_full_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHK && n_state == S_EOUT) |-> i_sts.full && i_sts.sum_zero)
        else $error("frame emission started without a whole, valid frame");

    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input and output sides active together");

    a_emit_ends_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EOUT && i_out_ready && i_sts.last) |=> i_sts.empty)
        else $error("window not empty after the last frame byte");
`endif

endmodule

`default_nettype wire
